### rtl/pidsd_pkg.sv
// ----------------------------------------------------------------------------
// pidsd_pkg
// Shared types and constants of the PID controller with settle detection.
// ----------------------------------------------------------------------------
package pidsd_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int DRIVE_W    = 48;
  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  localparam logic [31:0] LIMIT_RESET  = 32'd1310720;  // 20.0
  localparam logic [31:0] BAND_RESET   = 32'd3276800;  // 50.0
  localparam logic [15:0] SETTLE_RESET = 16'd50;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P          = 4'd0,
    REG_GAIN_I          = 4'd1,
    REG_GAIN_D          = 4'd2,
    REG_INTEGRAL_LIMIT  = 4'd3,
    REG_INTEGRAL_BAND   = 4'd4,
    REG_ERROR_TOLERANCE = 4'd5,
    REG_DERIV_TOLERANCE = 4'd6,
    REG_SETTLE_TIME     = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
    logic [31:0] integral_limit;
    logic [31:0] integral_band;
    logic [15:0] error_tolerance;
    logic [31:0] deriv_tolerance;
    logic [15:0] settle_time;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_INTEG,
    ST_MUL_CLAMP,
    ST_CLAMP_CHK,
    ST_DIV,
    ST_DIV_APPLY,
    ST_FINISH,
    ST_MUL_I,
    ST_LATCH_I,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic mul_p;
    logic mul_d;
    logic integ;
    logic mul_clamp;
    logic div_start;
    logic div_step;
    logic div_apply;
    logic finish;
    logic mul_i;
    logic latch_i;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clamp_hit;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

### rtl/pidsd_cfg.sv
// ----------------------------------------------------------------------------
// pidsd_cfg
// Configuration register bank; out-of-range indexes are ignored.
// ----------------------------------------------------------------------------
module pidsd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pidsd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pidsd_pkg::CFG_DATA_W-1:0] cfg_data,
  output pidsd_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p          <= '0;
      cfg.gain_i          <= '0;
      cfg.gain_d          <= '0;
      cfg.integral_limit  <= pidsd_pkg::LIMIT_RESET;
      cfg.integral_band   <= pidsd_pkg::BAND_RESET;
      cfg.error_tolerance <= '0;
      cfg.deriv_tolerance <= '0;
      cfg.settle_time     <= pidsd_pkg::SETTLE_RESET;
    end else if (cfg_we) begin
      unique case (pidsd_pkg::reg_idx_t'(cfg_addr))
        pidsd_pkg::REG_GAIN_P:          cfg.gain_p          <= cfg_data;
        pidsd_pkg::REG_GAIN_I:          cfg.gain_i          <= cfg_data;
        pidsd_pkg::REG_GAIN_D:          cfg.gain_d          <= cfg_data;
        pidsd_pkg::REG_INTEGRAL_LIMIT:  cfg.integral_limit  <= cfg_data;
        pidsd_pkg::REG_INTEGRAL_BAND:   cfg.integral_band   <= cfg_data;
        pidsd_pkg::REG_ERROR_TOLERANCE: cfg.error_tolerance <= cfg_data[15:0];
        pidsd_pkg::REG_DERIV_TOLERANCE: cfg.deriv_tolerance <= cfg_data;
        pidsd_pkg::REG_SETTLE_TIME:     cfg.settle_time     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/pidsd_ctrl.sv
// ----------------------------------------------------------------------------
// pidsd_ctrl
// Sequencer: steps one request through multiply, clamp, divide and output.
// ----------------------------------------------------------------------------
module pidsd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pidsd_pkg::dp_status_t  status,
  output pidsd_pkg::dp_cmd_t     cmd
);

  pidsd_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      pidsd_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = pidsd_pkg::ST_MUL_P;
        end
      end
      pidsd_pkg::ST_MUL_P: begin
        cmd.mul_p  = 1'b1;
        state_next = pidsd_pkg::ST_MUL_D;
      end
      pidsd_pkg::ST_MUL_D: begin
        cmd.mul_d  = 1'b1;
        state_next = pidsd_pkg::ST_INTEG;
      end
      pidsd_pkg::ST_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = pidsd_pkg::ST_MUL_CLAMP;
      end
      pidsd_pkg::ST_MUL_CLAMP: begin
        cmd.mul_clamp = 1'b1;
        state_next    = pidsd_pkg::ST_CLAMP_CHK;
      end
      pidsd_pkg::ST_CLAMP_CHK: begin
        if (status.clamp_hit) begin
          cmd.div_start = 1'b1;
          state_next    = pidsd_pkg::ST_DIV;
        end else begin
          state_next = pidsd_pkg::ST_FINISH;
        end
      end
      pidsd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = pidsd_pkg::ST_DIV_APPLY;
        end
      end
      pidsd_pkg::ST_DIV_APPLY: begin
        cmd.div_apply = 1'b1;
        state_next    = pidsd_pkg::ST_FINISH;
      end
      pidsd_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = pidsd_pkg::ST_MUL_I;
      end
      pidsd_pkg::ST_MUL_I: begin
        cmd.mul_i  = 1'b1;
        state_next = pidsd_pkg::ST_LATCH_I;
      end
      pidsd_pkg::ST_LATCH_I: begin
        cmd.latch_i = 1'b1;
        state_next  = pidsd_pkg::ST_OUT;
      end
      pidsd_pkg::ST_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = pidsd_pkg::ST_IDLE;
        end
      end
      default: state_next = pidsd_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/pidsd_dp.sv
// ----------------------------------------------------------------------------
// pidsd_dp
// Datapath: controller state, shared 32x32 multiplier, restoring divider,
// drive summation with saturation and the output register.
// ----------------------------------------------------------------------------
module pidsd_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  pidsd_pkg::cfg_t                     cfg,
  input  pidsd_pkg::dp_cmd_t                  cmd,
  output pidsd_pkg::dp_status_t               status,
  input  logic signed [15:0]                  setpoint,
  input  logic signed [15:0]                  measurement,
  input  logic [31:0]                         now_ms,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pidsd_pkg::DRIVE_W-1:0] drive,
  output logic                                arrived
);

  // persistent state
  logic signed [16:0] prev_error;
  logic signed [31:0] error_sum;
  logic               first_pending;
  logic               arrived_flag;
  logic [31:0]        settle_start;

  // per-request work registers
  logic signed [16:0] err;
  logic [31:0]        now_q;
  logic signed [31:0] es_work;
  logic [47:0]        p_mag;
  logic               p_neg;
  logic [48:0]        d_mag;
  logic               d_neg;
  logic [62:0]        i_mag;
  logic               i_neg;
  logic [63:0]        prod;

  // divider
  logic [31:0]                      rem;
  logic [31:0]                      quo;
  logic [pidsd_pkg::DIV_CNT_W-1:0]  div_cnt;

  logic signed [16:0] err_in;
  logic [15:0]        err_abs;
  logic signed [17:0] delta;
  logic [16:0]        delta_abs;
  logic [31:0]        es_work_abs;
  logic [31:0]        error_sum_abs;
  logic signed [32:0] acc;
  logic signed [31:0] acc_sat;
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [32:0]        rem_sh;
  logic               div_ge;
  logic               zero_sum;
  logic               steady;
  logic signed [65:0] p_s;
  logic signed [65:0] d_s;
  logic signed [65:0] i_s;
  logic signed [65:0] sum;
  logic               sum_fits;
  logic [pidsd_pkg::DRIVE_W-1:0] drive_sat;

  assign err_in        = 17'(setpoint) - 17'(measurement);
  assign err_abs       = err[16] ? 16'(-err) : 16'(err);
  assign delta         = 18'(err) - 18'(prev_error);
  assign delta_abs     = delta[17] ? 17'(-delta) : 17'(delta);
  assign es_work_abs   = es_work[31] ? 32'(-es_work) : 32'(es_work);
  assign error_sum_abs = error_sum[31] ? 32'(-error_sum) : 32'(error_sum);

  assign acc     = 33'(error_sum) + 33'(err);
  assign acc_sat = (acc[32] != acc[31]) ? {acc[32], {31{~acc[32]}}} : acc[31:0];

  always_comb begin
    mul_a = cfg.gain_p;
    mul_b = {16'b0, err_abs[15:0]};
    priority if (cmd.mul_d) begin
      mul_a = cfg.gain_d;
      mul_b = {15'b0, delta_abs[16:0]};
    end else if (cmd.mul_clamp) begin
      mul_a = cfg.gain_i;
      mul_b = es_work_abs;
    end else if (cmd.mul_i) begin
      mul_a = cfg.gain_i;
      mul_b = error_sum_abs;
    end else begin
      mul_a = cfg.gain_p;
      mul_b = {16'b0, err_abs[15:0]};
    end
  end

  assign rem_sh = {rem, quo[31]};
  assign div_ge = rem_sh >= {1'b0, cfg.gain_i};

  assign zero_sum = (err == '0) || (es_work[31] != err[16])
                    || ({1'b0, err_abs[15:0]} <= {1'b0, cfg.error_tolerance});
  assign steady   = (err_abs[15:0] <= cfg.error_tolerance)
                    && (d_mag <= {17'b0, cfg.deriv_tolerance});

  assign p_s = p_neg ? -$signed({18'b0, p_mag}) : $signed({18'b0, p_mag});
  assign d_s = d_neg ? -$signed({17'b0, d_mag}) : $signed({17'b0, d_mag});
  assign i_s = i_neg ? -$signed({3'b0, i_mag})  : $signed({3'b0, i_mag});
  assign sum = p_s + d_s + i_s;

  assign sum_fits  = (&sum[65:pidsd_pkg::DRIVE_W-1]) || !(|sum[65:pidsd_pkg::DRIVE_W-1]);
  assign drive_sat = sum_fits ? sum[pidsd_pkg::DRIVE_W-1:0]
                   : (sum[65] ? pidsd_pkg::DRIVE_MIN : pidsd_pkg::DRIVE_MAX);

  assign status.clamp_hit = prod > {32'b0, cfg.integral_limit};
  assign status.div_last  = div_cnt == pidsd_pkg::DIV_CNT_W'(pidsd_pkg::DIV_W - 1);
  assign status.out_busy  = out_valid && !out_ready;

  // control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error    <= '0;
      error_sum     <= '0;
      first_pending <= 1'b1;
      arrived_flag  <= 1'b0;
      settle_start  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load && (restart || first_pending)) begin
        first_pending <= 1'b0;
        prev_error    <= err_in;
        error_sum     <= '0;
      end
      if (cmd.mul_d) begin
        prev_error <= err;
      end
      if (cmd.finish) begin
        error_sum <= zero_sum ? '0 : es_work;
        if (steady) begin
          if ((now_q - settle_start) >= {16'b0, cfg.settle_time}) begin
            arrived_flag <= 1'b1;
          end
        end else begin
          settle_start <= now_q;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err   <= err_in;
      now_q <= now_ms;
    end
    if (cmd.mul_p || cmd.mul_d || cmd.mul_clamp || cmd.mul_i) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.mul_d) begin
      p_mag <= prod[47:0];
      p_neg <= err[16];
      d_neg <= delta[17];
    end
    if (cmd.integ) begin
      d_mag <= prod[48:0];
      if (p_mag >= {16'b0, cfg.integral_band}) begin
        es_work <= '0;
      end else begin
        es_work <= acc_sat;
      end
    end
    if (cmd.div_start) begin
      rem     <= '0;
      quo     <= cfg.integral_limit;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= div_ge ? 32'(rem_sh - {1'b0, cfg.gain_i}) : rem_sh[31:0];
      quo     <= {quo[30:0], div_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.div_apply) begin
      es_work <= es_work[31] ? 32'(-quo) : quo;
    end
    if (cmd.mul_i) begin
      i_neg <= error_sum[31];
    end
    if (cmd.latch_i) begin
      i_mag <= prod[62:0];
    end
    if (cmd.out_load) begin
      drive   <= drive_sat;
      arrived <= arrived_flag;
    end
  end

endmodule

### rtl/pid_with_settle_detect.sv
// ----------------------------------------------------------------------------
// pid_with_settle_detect
// PID controller with integral separation, anti-windup clamp and settle
// detection; sticky arrived flag once error and D stay in tolerance.
//
//   channel  dir  handshake                     payload
//   s_axis   in   s_axis_tvalid/s_axis_tready   setpoint, measurement, now_ms, restart
//   m_axis   out  m_axis_tvalid/m_axis_tready   drive, arrived
//   cfg      in   cfg_we                        cfg_addr, cfg_data
//
// One request is worked on at a time; when the integral clamp fires, the clamp
// value comes from a 32-step restoring divider (integral_limit / gain_i), and
// all products share one registered 32x32 multiplier.
// Reset is synchronous; it loads register defaults and clears the state, and
// no request is taken while it is held.
// A finished result waits in the output register while the next request is
// taken; a request only stalls when it finishes with the previous one unread.
// ----------------------------------------------------------------------------
module pid_with_settle_detect (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [63:0]                      s_axis_tdata,  // setpoint, measurement, now_ms
  input  logic                             s_axis_tuser,  // restart
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pidsd_pkg::DRIVE_W-1:0]    m_axis_tdata,  // drive
  output logic                             m_axis_tuser,  // arrived
  input  logic                             cfg_we,
  input  logic [pidsd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pidsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  pidsd_pkg::cfg_t       cfg;
  pidsd_pkg::dp_cmd_t    cmd;
  pidsd_pkg::dp_status_t status;
  logic signed [pidsd_pkg::DRIVE_W-1:0] drive;

  pidsd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  pidsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pidsd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .setpoint    ($signed(s_axis_tdata[15:0])),
    .measurement ($signed(s_axis_tdata[31:16])),
    .now_ms      (s_axis_tdata[63:32]),
    .restart     (s_axis_tuser),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .drive       (drive),
    .arrived     (m_axis_tuser)
  );

  assign m_axis_tdata = drive;

endmodule

### rtl/pidsd_chk.sv
// ----------------------------------------------------------------------------
// pidsd_chk
// Port-level checks of the PID block, bound to the top level.
// ----------------------------------------------------------------------------
module pidsd_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pidsd_pkg::DRIVE_W-1:0]    m_axis_tdata,
  input logic                             m_axis_tuser
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;
  logic       seen_arrived;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // requests in flight: taken but result not yet read
  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= '0;
      seen_arrived <= 1'b0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc && m_axis_tuser) begin
        seen_arrived <= 1'b1;
      end
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pending != 2'd0))
    else $error("result without a pending request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (pending != 2'd2))
    else $error("request taken with two already in flight");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && seen_arrived |-> m_axis_tuser)
    else $error("arrived flag cleared without reset");

endmodule

bind pid_with_settle_detect pidsd_chk u_pidsd_chk (.*);
